@@ src/ert_pkg.sv @@
// Shared types and constants for the echo request tracker.
package ert_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_T_SCAN,
        ST_T_EMIT,
        ST_R_SCAN,
        ST_R_DONE
    } ert_state_t;

    // Input operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_ISSUED  = 3'd0;
    localparam logic [2:0] KIND_EXPIRED = 3'd1;
    localparam logic [2:0] KIND_MATCHED = 3'd2;
    localparam logic [2:0] KIND_LATE    = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_IDENT    = 2'd2;
    localparam logic [1:0] CFG_TARGET   = 2'd3;

    localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;

    // One tracking table entry
    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] stamp;
    } ert_entry_t;

    // Saturating 16-bit increment
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        logic [15:0] r;
        r = (v == 16'hFFFF) ? v : v + 16'd1;
        return r;
    endfunction

endpackage

@@ src/echo_request_tracker.sv @@
// Top level of the echo request tracker.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  input     | start, busy            | op, reply_type, reply_ident, reply_seq
//  result    | result_valid (strobe)  | kind, seq_number, round_trip, untracked,
//            |                        | finished, last_of_run, *_count
//  config    | cfg_we                 | cfg_index, cfg_data
//
// A tick makes one pass over the slot RAM to find expired entries, then a
// second pass to read their sequence numbers out.
// A valid reply makes one RAM pass, then applies the match in ST_R_DONE;
// an ignored reply, a reply after completion or a tick after completion needs no pass.
// The single read port of the slot RAM is why each pass reads the slots one by one.
// Reset clears all control state and valid bits; the RAM needs no clearing.
// Results are strobed for one cycle each; the receiver cannot stall.
module echo_request_tracker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [7:0]  reply_type,
    input  logic [15:0] reply_ident,
    input  logic [15:0] reply_seq,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [2:0]  kind,
    output logic [15:0] seq_number,
    output logic [31:0] round_trip,
    output logic        untracked,
    output logic        finished,
    output logic        last_of_run,
    output logic [15:0] issued_count,
    output logic [15:0] answered_count,
    output logic [15:0] timed_out_count
);
    import ert_pkg::*;

    localparam int D  = TABLE_DEPTH;
    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);
    localparam logic [CW-1:0] DCNT = CW'(D);

    ert_state_t state_reg, state_next;

    logic [15:0] interval_reg, timeout_reg, ident_reg, target_reg;
    logic [31:0] now_reg, now_next;
    logic [31:0] last_issue_reg, last_issue_next;
    logic        pend_reg, pend_next;
    logic [15:0] next_seq_reg, next_seq_next;
    logic [D-1:0] valid_reg, valid_next;
    logic [D-1:0] expd_reg, expd_next;
    logic [D-1:0] expv_reg, expv_next;
    logic [15:0] issued_reg, issued_next;
    logic [15:0] answered_reg, answered_next;
    logic [15:0] tout_reg, tout_next;
    logic        done_reg, done_next;

    logic [CW-1:0] idx_reg, idx_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] ecnt_reg, ecnt_next;
    logic          iss_flag_reg, iss_flag_next;
    logic [15:0]   iss_seq_reg, iss_seq_next;
    logic          iss_untr_reg, iss_untr_next;
    logic [15:0]   req_seq_reg, req_seq_next;
    logic          vhit_reg, vhit_next, ehit_reg, ehit_next;
    logic [AW-1:0] vidx_reg, vidx_next, eidx_reg, eidx_next;
    logic [31:0]   vrtt_reg, vrtt_next, ertt_reg, ertt_next;

    logic        out_vld_reg, out_vld_next;
    logic [2:0]  out_kind_reg, out_kind_next;
    logic [15:0] out_seq_reg, out_seq_next;
    logic [31:0] out_rtt_reg, out_rtt_next;
    logic        out_untr_reg, out_untr_next;
    logic        out_last_reg, out_last_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    ert_entry_t    mem_wdata, mem_rdata;

    logic          free_found;
    logic [AW-1:0] free_idx;
    logic [31:0]   age;
    logic [15:0]   ans_new;
    logic [16:0]   sum_new;

    ert_slot_ram #(.DEPTH(D), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = D - 1; i >= 0; i--)
        begin
            if (!valid_reg[i] && !expd_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    assign age = now_reg - mem_rdata.stamp;

    // Next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        last_issue_next = last_issue_reg;
        pend_next       = pend_reg;
        next_seq_next   = next_seq_reg;
        valid_next      = valid_reg;
        expd_next       = expd_reg;
        expv_next       = expv_reg;
        issued_next     = issued_reg;
        answered_next   = answered_reg;
        tout_next       = tout_reg;
        done_next       = done_reg;
        idx_next        = idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        ecnt_next       = ecnt_reg;
        iss_flag_next   = iss_flag_reg;
        iss_seq_next    = iss_seq_reg;
        iss_untr_next   = iss_untr_reg;
        req_seq_next    = req_seq_reg;
        vhit_next       = vhit_reg;
        ehit_next       = ehit_reg;
        vidx_next       = vidx_reg;
        eidx_next       = eidx_reg;
        vrtt_next       = vrtt_reg;
        ertt_next       = ertt_reg;
        out_vld_next    = 1'b0;
        out_kind_next   = out_kind_reg;
        out_seq_next    = out_seq_reg;
        out_rtt_next    = out_rtt_reg;
        out_untr_next   = out_untr_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx;
        mem_wdata.seq   = next_seq_reg;
        mem_wdata.stamp = now_reg + 32'd1;
        ans_new         = answered_reg;
        sum_new         = '0;

        // RAM sweep address sequencing, used by every scanning state
        if (state_reg != ST_IDLE && state_reg != ST_R_DONE && idx_reg < DCNT)
        begin
            idx_next    = idx_reg + CW'(1);
            rd_vld_next = 1'b1;
            rd_idx_next = idx_reg[AW-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    if (op == OP_TICK)
                    begin
                        if (!done_reg)
                        begin
                            now_next      = now_reg + 32'd1;
                            iss_flag_next = 1'b0;
                            if (pend_reg || (now_next - last_issue_reg) >= {16'd0, interval_reg})
                            begin
                                iss_flag_next   = 1'b1;
                                iss_seq_next    = next_seq_reg;
                                iss_untr_next   = !free_found;
                                next_seq_next   = next_seq_reg + 16'd1;
                                issued_next     = sat_inc(issued_reg);
                                last_issue_next = now_next;
                                pend_next       = 1'b0;
                                if (free_found)
                                begin
                                    mem_we               = 1'b1;
                                    valid_next[free_idx] = 1'b1;
                                end
                            end
                            expv_next  = '0;
                            ecnt_next  = '0;
                            state_next = ST_T_SCAN;
                        end
                    end
                    else if (done_reg || reply_type != TYPE_ECHO_REPLY
                             || reply_ident != ident_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_kind_next = KIND_IGNORED;
                        out_seq_next  = reply_seq;
                        out_rtt_next  = '0;
                        out_untr_next = 1'b0;
                        out_last_next = 1'b1;
                        // Completion is checked on every reply
                        sum_new       = {1'b0, answered_reg} + {1'b0, tout_reg};
                        if (target_reg != 16'd0 && sum_new >= {1'b0, target_reg})
                        begin
                            done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        req_seq_next = reply_seq;
                        vhit_next    = 1'b0;
                        ehit_next    = 1'b0;
                        state_next   = ST_R_SCAN;
                    end
                end
            end

            // Find entries that reached the timeout
            ST_T_SCAN:
            begin
                if (rd_vld_reg && valid_reg[rd_idx_reg] && age >= {16'd0, timeout_reg})
                begin
                    valid_next[rd_idx_reg] = 1'b0;
                    expd_next[rd_idx_reg]  = 1'b1;
                    expv_next[rd_idx_reg]  = 1'b1;
                    tout_next              = sat_inc(tout_reg);
                    ecnt_next              = ecnt_reg + CW'(1);
                end
                if (idx_reg == DCNT && !rd_vld_reg)
                begin
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    state_next  = ST_T_EMIT;
                end
            end

            // Issued request first, then expired slots in slot order
            ST_T_EMIT:
            begin
                if (iss_flag_reg)
                begin
                    iss_flag_next = 1'b0;
                    out_vld_next  = 1'b1;
                    out_kind_next = KIND_ISSUED;
                    out_seq_next  = iss_seq_reg;
                    out_rtt_next  = '0;
                    out_untr_next = iss_untr_reg;
                    out_last_next = (ecnt_reg == '0);
                end
                else if (rd_vld_reg && expv_reg[rd_idx_reg])
                begin
                    ecnt_next     = ecnt_reg - CW'(1);
                    out_vld_next  = 1'b1;
                    out_kind_next = KIND_EXPIRED;
                    out_seq_next  = mem_rdata.seq;
                    out_rtt_next  = '0;
                    out_untr_next = 1'b0;
                    out_last_next = (ecnt_reg == CW'(1));
                end
                if (idx_reg == DCNT && !rd_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            // Lowest live match and lowest expired match
            ST_R_SCAN:
            begin
                if (rd_vld_reg && mem_rdata.seq == req_seq_reg)
                begin
                    if (!vhit_reg && valid_reg[rd_idx_reg])
                    begin
                        vhit_next = 1'b1;
                        vidx_next = rd_idx_reg;
                        vrtt_next = age;
                    end
                    else if (!ehit_reg && expd_reg[rd_idx_reg])
                    begin
                        ehit_next = 1'b1;
                        eidx_next = rd_idx_reg;
                        ertt_next = age;
                    end
                end
                if (idx_reg == DCNT && !rd_vld_reg)
                begin
                    state_next = ST_R_DONE;
                end
            end

            // Apply the match and report it
            ST_R_DONE:
            begin
                out_vld_next  = 1'b1;
                out_seq_next  = req_seq_reg;
                out_untr_next = 1'b0;
                out_last_next = 1'b1;
                if (vhit_reg)
                begin
                    valid_next[vidx_reg] = 1'b0;
                    ans_new              = sat_inc(answered_reg);
                    out_kind_next        = KIND_MATCHED;
                    out_rtt_next         = vrtt_reg;
                end
                else if (ehit_reg)
                begin
                    expd_next[eidx_reg] = 1'b0;
                    out_kind_next       = KIND_LATE;
                    out_rtt_next        = ertt_reg;
                end
                else
                begin
                    out_kind_next = KIND_IGNORED;
                    out_rtt_next  = '0;
                end
                answered_next = ans_new;
                sum_new       = {1'b0, ans_new} + {1'b0, tout_reg};
                if (target_reg != 16'd0 && sum_new >= {1'b0, target_reg})
                begin
                    done_next = 1'b1;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            last_issue_reg <= '0;
            pend_reg       <= 1'b1;
            next_seq_reg   <= 16'd1;
            valid_reg      <= '0;
            expd_reg       <= '0;
            expv_reg       <= '0;
            issued_reg     <= '0;
            answered_reg   <= '0;
            tout_reg       <= '0;
            done_reg       <= 1'b0;
            idx_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            ecnt_reg       <= '0;
            iss_flag_reg   <= 1'b0;
            vhit_reg       <= 1'b0;
            ehit_reg       <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            last_issue_reg <= last_issue_next;
            pend_reg       <= pend_next;
            next_seq_reg   <= next_seq_next;
            valid_reg      <= valid_next;
            expd_reg       <= expd_next;
            expv_reg       <= expv_next;
            issued_reg     <= issued_next;
            answered_reg   <= answered_next;
            tout_reg       <= tout_next;
            done_reg       <= done_next;
            idx_reg        <= idx_next;
            rd_vld_reg     <= rd_vld_next;
            ecnt_reg       <= ecnt_next;
            iss_flag_reg   <= iss_flag_next;
            vhit_reg       <= vhit_next;
            ehit_reg       <= ehit_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        iss_seq_reg  <= iss_seq_next;
        iss_untr_reg <= iss_untr_next;
        req_seq_reg  <= req_seq_next;
        vidx_reg     <= vidx_next;
        eidx_reg     <= eidx_next;
        vrtt_reg     <= vrtt_next;
        ertt_reg     <= ertt_next;
        out_kind_reg <= out_kind_next;
        out_seq_reg  <= out_seq_next;
        out_rtt_reg  <= out_rtt_next;
        out_untr_reg <= out_untr_next;
        out_last_reg <= out_last_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= 16'd1000;
            timeout_reg  <= 16'd1000;
            ident_reg    <= 16'd0;
            target_reg   <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERVAL: interval_reg <= cfg_data;
                CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                CFG_IDENT:    ident_reg    <= cfg_data;
                CFG_TARGET:   target_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign result_valid    = out_vld_reg;
    assign kind            = out_kind_reg;
    assign seq_number      = out_seq_reg;
    assign round_trip      = out_rtt_reg;
    assign untracked       = out_untr_reg;
    assign last_of_run     = out_last_reg;
    assign finished        = done_reg;
    assign issued_count    = issued_reg;
    assign answered_count  = answered_reg;
    assign timed_out_count = tout_reg;

endmodule

@@ src/ert_slot_ram.sv @@
// Slot table memory: one write port, one registered read port.
module ert_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  ert_pkg::ert_entry_t wdata,
    input  logic [AW-1:0]       raddr,
    output ert_pkg::ert_entry_t rdata
);
    import ert_pkg::*;

    ert_entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ src/ert_checker.sv @@
// Port-level checker for the echo request tracker, with its bind.
module ert_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic [2:0]  kind,
    input logic [31:0] round_trip,
    input logic        untracked,
    input logic        finished,
    input logic [15:0] issued_count
);
    import ert_pkg::*;

    // Only issued results may be untracked
    a_untr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != KIND_ISSUED |-> !untracked)
        else $error("untracked set on non-issue result");

    // Round trip only on matched or late replies
    a_rtt: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_ISSUED || kind == KIND_EXPIRED
                         || kind == KIND_IGNORED) |-> round_trip == 32'd0)
        else $error("round trip on wrong kind");

    // Completion is sticky
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        $past(finished) |-> finished)
        else $error("finished dropped");

    // Issue count never goes back
    a_iss: assert property (@(posedge clk) disable iff (!rst_n)
        issued_count >= $past(issued_count))
        else $error("issued count decreased");

endmodule

bind echo_request_tracker ert_checker u_ert_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .kind         (kind),
    .round_trip   (round_trip),
    .untracked    (untracked),
    .finished     (finished),
    .issued_count (issued_count)
);
